// ===== hdl/bmd_pkg.sv =====
// Package for the block mean downsampler.
// Holds fixed field widths, size limits, register indexes and the control state type.
// No dependencies.
package bmd_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_FACTOR = 16;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned FACT_W  = 5;
  localparam int unsigned FW_W    = 13;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 13;

  localparam logic [CIDX_W-1:0] CFG_FACTOR    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_WIDTH     = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_COL_FIRST = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_COL_LAST  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_ROW_FIRST = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_ROW_LAST  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] bc;
    logic [COORD_W-1:0] br;
    logic               row_done;
    logic               first;
    logic               last;
  } blk_pos_t;

endpackage

// ===== hdl/block_mean_downsampler.sv =====
// Block mean downsampler: averages the valid pixels of square blocks of a region.
// Top level; uses bmd_pkg, bmd_line_store and bmd_div.
//
// Channels: a pixel input (pixel_value, pixel_valid, frame_start) and a block
// result output (block_mean, block_valid, block_col, block_row, row_done), both
// valid/ready; a configuration write channel (index, data) that is always ready.
// Pixels arrive in raster order. Each pixel of a whole block in the region is one
// read-modify-write of the line store entry of its block column (a read, then a
// write back). A pixel that ends a block with valid pixels also runs the mean
// through the bit-serial divider; an empty block skips it. No new pixel is taken
// until this is done and the block result has gone into the output register.
// The result sits in an output register; pixels keep flowing while it waits,
// and the next block result waits until that register is taken.
// Reset clears the position counters and the configuration to its defaults;
// the line store is not cleared, each block entry is written by its first pixel.
module block_mean_downsampler #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bmd_pkg::CIDX_W-1:0]          cfg_index_i,
  input  logic [bmd_pkg::CDAT_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       pixel_value_i,
  input  logic                                pixel_valid_i,
  input  logic                                frame_start_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       block_mean_o,
  output logic                                block_valid_o,
  output logic [bmd_pkg::COORD_W-1:0]         block_col_o,
  output logic [bmd_pkg::COORD_W-1:0]         block_row_o,
  output logic                                row_done_o
);

  import bmd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int unsigned SW = SAMPLE_BITS + CW;

  logic [FACT_W-1:0]  factor_q;
  logic [FW_W-1:0]    width_q;
  logic [COORD_W-1:0] col_first_q, col_last_q, row_first_q, row_last_q;

  state_e state_q, state_d;

  logic [FW_W-1:0]    pcol_q;
  logic [COORD_W-1:0] prow_q;
  logic [FACT_W-1:0]  dc_q, dr_q;
  logic [COORD_W-1:0] bc_q, br_q;
  logic [POS_W-1:0]   bs_q, rs_q;

  logic [FACT_W-1:0]  f, fm1, dc_d, dr_d, dr_c;
  logic [FW_W-1:0]    w, wm1, col, pcol_d;
  logic [COORD_W-1:0] cl, row, bc_d, br_d, br_c, prow_d, nrow;
  logic [POS_W-1:0]   bs_d, rs_d, rs_c;
  logic               hit, eor;
  blk_pos_t           pos_c, pos_q;

  logic signed [SAMPLE_BITS-1:0] pix_q;
  logic                          pvalid_q;

  logic               in_acc, cfg_acc;
  logic [SW+CW-1:0]   rdata, wdata;
  logic signed [SW-1:0] sum_old, sum_new, vext;
  logic [CW-1:0]      cnt_old, cnt_new;
  logic               div_start, div_done;
  logic signed [SW-1:0] quot;

  logic signed [SAMPLE_BITS-1:0] res_mean_q;
  logic                          res_valid_q;
  logic                          out_valid_q;
  logic                          out_load;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q    <= FACT_W'(1);
      width_q     <= FW_W'(4096);
      col_first_q <= '0;
      col_last_q  <= COORD_W'(4095);
      row_first_q <= '0;
      row_last_q  <= COORD_W'(4095);
    end else if (cfg_acc) begin
      case (cfg_index_i)
        CFG_FACTOR:    factor_q    <= cfg_data_i[FACT_W-1:0];
        CFG_WIDTH:     width_q     <= cfg_data_i[FW_W-1:0];
        CFG_COL_FIRST: col_first_q <= cfg_data_i[COORD_W-1:0];
        CFG_COL_LAST:  col_last_q  <= cfg_data_i[COORD_W-1:0];
        CFG_ROW_FIRST: row_first_q <= cfg_data_i[COORD_W-1:0];
        CFG_ROW_LAST:  row_last_q  <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (factor_q == '0) begin
      f = FACT_W'(1);
    end else if (int'(factor_q) > MAX_FACTOR) begin
      f = FACT_W'(MAX_FACTOR);
    end else begin
      f = factor_q;
    end
    fm1 = f - FACT_W'(1);
    if (width_q == '0) begin
      w = FW_W'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w = FW_W'(MAX_WIDTH);
    end else begin
      w = width_q;
    end
    wm1 = w - FW_W'(1);
    cl  = (FW_W'(col_last_q) > wm1) ? wm1[COORD_W-1:0] : col_last_q;
    col = (frame_start_i || pcol_q >= w) ? '0 : pcol_q;
    row = frame_start_i ? '0 : prow_q;

    if (col == FW_W'(col_first_q)) begin
      dc_d = '0;
      bc_d = '0;
      bs_d = POS_W'(col_first_q);
    end else if (dc_q == fm1) begin
      dc_d = '0;
      bc_d = bc_q + COORD_W'(1);
      bs_d = bs_q + POS_W'(f);
    end else begin
      dc_d = dc_q + FACT_W'(1);
      bc_d = bc_q;
      bs_d = bs_q;
    end

    if (frame_start_i && row_first_q == '0) begin
      dr_c = '0;
      br_c = '0;
      rs_c = '0;
    end else begin
      dr_c = dr_q;
      br_c = br_q;
      rs_c = rs_q;
    end

    hit = (col >= FW_W'(col_first_q)) && (row >= row_first_q) &&
          (bs_d + POS_W'(f) - POS_W'(1) <= POS_W'(cl)) &&
          (rs_c + POS_W'(f) - POS_W'(1) <= POS_W'(row_last_q));
    pos_c.bc       = bc_d;
    pos_c.br       = br_c;
    pos_c.row_done = (bs_d + POS_W'(f) + POS_W'(f) - POS_W'(1) > POS_W'(cl));
    pos_c.first    = (dc_d == '0) && (dr_c == '0);
    pos_c.last     = (dc_d == fm1) && (dr_c == fm1);

    eor  = (POS_W'(col) + POS_W'(1) >= POS_W'(w));
    nrow = row + COORD_W'(1);
    if (eor) begin
      pcol_d = '0;
      prow_d = nrow;
      if (nrow == row_first_q) begin
        dr_d = '0;
        br_d = '0;
        rs_d = POS_W'(row_first_q);
      end else if (nrow > row_first_q && dr_c == fm1) begin
        dr_d = '0;
        br_d = br_c + COORD_W'(1);
        rs_d = rs_c + POS_W'(f);
      end else if (nrow > row_first_q) begin
        dr_d = dr_c + FACT_W'(1);
        br_d = br_c;
        rs_d = rs_c;
      end else begin
        dr_d = dr_c;
        br_d = br_c;
        rs_d = rs_c;
      end
    end else begin
      pcol_d = col + FW_W'(1);
      prow_d = row;
      dr_d   = dr_c;
      br_d   = br_c;
      rs_d   = rs_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q <= '0;
      prow_q <= '0;
      dc_q   <= '0;
      bc_q   <= '0;
      bs_q   <= '0;
      dr_q   <= '0;
      br_q   <= '0;
      rs_q   <= '0;
    end else if (in_acc) begin
      pcol_q <= pcol_d;
      prow_q <= prow_d;
      dc_q   <= dc_d;
      bc_q   <= bc_d;
      bs_q   <= bs_d;
      dr_q   <= dr_d;
      br_q   <= br_d;
      rs_q   <= rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q    <= pos_c;
      pix_q    <= pixel_value_i;
      pvalid_q <= pixel_valid_i;
    end
  end

  bmd_line_store #(
    .DEPTH(MAX_WIDTH),
    .DW   (SW + CW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (state_q == S_UPD),
    .waddr_i(AW'(pos_q.bc)),
    .wdata_i(wdata),
    .re_i   (in_acc && hit),
    .raddr_i(AW'(bc_d)),
    .rdata_o(rdata)
  );

  always_comb begin
    sum_old = $signed(rdata[SW-1:0]);
    cnt_old = rdata[SW+CW-1:SW];
    vext    = SW'(pix_q);
    if (pos_q.first) begin
      sum_new = pvalid_q ? vext : '0;
      cnt_new = pvalid_q ? CW'(1) : '0;
    end else if (pvalid_q) begin
      sum_new = sum_old + vext;
      cnt_new = cnt_old + CW'(1);
    end else begin
      sum_new = sum_old;
      cnt_new = cnt_old;
    end
    wdata     = {cnt_new, sum_new};
    div_start = (state_q == S_UPD) && pos_q.last && (cnt_new != '0);
  end

  bmd_div #(
    .SW(SW),
    .CW(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_new),
    .divisor_i (cnt_new),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc && hit) state_d = S_UPD;
      S_UPD: begin
        if (!pos_q.last) begin
          state_d = S_IDLE;
        end else if (cnt_new != '0) begin
          state_d = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD && pos_q.last && cnt_new == '0) begin
      res_mean_q  <= '0;
      res_valid_q <= 1'b0;
    end else if (div_done) begin
      res_mean_q  <= quot[SAMPLE_BITS-1:0];
      res_valid_q <= 1'b1;
    end
    if (out_load) begin
      block_mean_o  <= res_mean_q;
      block_valid_o <= res_valid_q;
      block_col_o   <= pos_q.bc;
      block_row_o   <= pos_q.br;
      row_done_o    <= pos_q.row_done;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/bmd_line_store.sv =====
// Line store of per-column block sums and valid counts.
// One write port and one read port, read data registered. No dependencies.
module bmd_line_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned DW    = 49
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/bmd_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero. No dependencies.
module bmd_div #(
  parameter int unsigned SW = 41,
  parameter int unsigned CW = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [SW-1:0] dividend_i,
  input  logic [CW-1:0]        divisor_i,
  output logic                 done_o,
  output logic signed [SW-1:0] quotient_o
);

  localparam int unsigned SC_W = $clog2(SW + 1);

  logic            busy_q;
  logic [SC_W-1:0] step_q;
  logic [SW-1:0]   num_q;
  logic [CW-1:0]   rem_q;
  logic [CW-1:0]   den_q;
  logic            neg_q;
  logic            done_q;
  logic [CW:0]     trial;
  logic            qbit;
  logic [CW:0]     diff;

  always_comb begin
    trial = {rem_q, num_q[SW-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + SC_W'(1);
        if (step_q == SC_W'(SW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i[SW-1] ? SW'(-dividend_i) : dividend_i;
      neg_q <= dividend_i[SW-1];
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[SW-2:0], qbit};
      rem_q <= qbit ? diff[CW-1:0] : trial[CW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(num_q) : $signed(num_q);

endmodule

// ===== hdl/bmd_checker.sv =====
// Port-level checks for the block mean downsampler.
// Bound to block_mean_downsampler; no other dependencies.
module bmd_checker #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] block_mean_o,
  input logic                   block_valid_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(block_mean_o))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !block_valid_o |-> block_mean_o == '0)
    else $error("empty block carries a nonzero mean");

  a_busy_before_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a busy cycle");

endmodule

bind block_mean_downsampler bmd_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_bmd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .block_mean_o (block_mean_o),
  .block_valid_o(block_valid_o)
);

// ===== dv/tb_block_mean_downsampler.sv =====
// Testbench for block_mean_downsampler: streams pixels under several region
// settings and checks every block result against an in-bench line-store
// predictor or a directed table. Depends on bmd_pkg and block_mean_downsampler.
`timescale 1ns / 1ps

module tb_block_mean_downsampler;
  import bmd_pkg::*;

  localparam int unsigned MAX_W    = 4096;
  localparam int unsigned MAX_F    = 16;
  localparam int unsigned N_ITEMS  = 950;
  localparam int unsigned WD_LIMIT = 4000;
  localparam int unsigned DRAIN    = 60;

  typedef struct packed {
    logic signed [31:0]  mean;
    logic                vld;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic                done;
  } blk_res_t;

  typedef struct packed {
    logic                cfg_b;
    logic                fs;
    logic signed [31:0]  val;
    logic                vld;
    logic                chk;
    blk_res_t            res;
  } pix_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CIDX_W-1:0] cfg_index = CFG_FACTOR;
  logic [CDAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic signed [31:0] pix_value = '0;
  logic pix_vld = 1'b0;
  logic frame_start = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_ready, in_ready, out_valid;
  logic signed [31:0] block_mean;
  logic block_valid, row_done;
  logic [COORD_W-1:0] block_col, block_row;

  block_mean_downsampler u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pixel_value_i(pix_value), .pixel_valid_i(pix_vld), .frame_start_i(frame_start),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .block_mean_o(block_mean), .block_valid_o(block_valid),
    .block_col_o(block_col), .block_row_o(block_row), .row_done_o(row_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [4:0]         r_factor;
  logic [12:0]        r_width;
  logic [11:0]        r_col_first, r_col_last, r_row_first, r_row_last;
  longint             line_sum [MAX_W];
  int unsigned        line_cnt [MAX_W];
  int unsigned        pos_col, pos_row;

  blk_res_t           mean_q[$];
  int unsigned        errors = 0;
  int unsigned        tx_idle = 0, rx_idle = 0;
  int unsigned        quiet_cycles = 0;

  function automatic bit predict_block(input logic fs, input logic signed [31:0] val,
                                       input logic vld, output blk_res_t r);
    int unsigned f, w, cl, col, row, ncols, nrows, bc, br, dc, dr;
    longint mean;
    bit hit;
    f = 32'(r_factor);
    if (f < 1) f = 1;
    if (f > MAX_F) f = MAX_F;
    w = 32'(r_width);
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    hit = 1'b0;
    r = '0;
    if (fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    if (pos_col >= w) pos_col = 0;
    col = pos_col;
    row = pos_row;
    cl = 32'(r_col_last);
    if (cl > w - 1) cl = w - 1;
    ncols = (cl >= r_col_first) ? (cl - r_col_first + 1) / f : 0;
    nrows = (r_row_last >= r_row_first) ? (r_row_last - r_row_first + 1) / f : 0;
    if (col >= r_col_first && row >= r_row_first) begin
      bc = (col - r_col_first) / f;
      br = (row - r_row_first) / f;
      if (bc < ncols && br < nrows) begin
        dc = (col - r_col_first) % f;
        dr = (row - r_row_first) % f;
        if (dc == 0 && dr == 0) begin
          line_sum[bc] = vld ? longint'(val) : 0;
          line_cnt[bc] = vld ? 1 : 0;
        end else if (vld) begin
          line_sum[bc] += longint'(val);
          line_cnt[bc] = (line_cnt[bc] + 1) & 511;
        end
        if (dc == f - 1 && dr == f - 1) begin
          mean = 0;
          if (line_cnt[bc] != 0) mean = line_sum[bc] / longint'(line_cnt[bc]);
          r.mean = mean[31:0];
          r.vld = line_cnt[bc] != 0;
          r.col = bc[11:0];
          r.row = br[11:0];
          r.done = bc == ncols - 1;
          hit = 1'b1;
        end
      end
    end
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row = (pos_row + 1) & 4095;
    end else begin
      pos_col++;
    end
    return hit;
  endfunction

  task automatic send_pixel(input logic fs, input logic signed [31:0] val, input logic vld,
                            input logic chk, input blk_res_t exp_res);
    blk_res_t r;
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_valid <= 1'b1;
    frame_start <= fs;
    pix_value <= val;
    pix_vld <= vld;
    do @(posedge clk); while (!in_ready);
    if (predict_block(fs, val, vld, r)) mean_q = {mean_q, (chk ? exp_res : r)};
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (mean_q.size() != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_cfg(input int unsigned fac, input int unsigned wid,
                           input int unsigned cf, input int unsigned cl,
                           input int unsigned rf, input int unsigned rl);
    logic [12:0] vals [6];
    logic [CIDX_W-1:0] idx [6];
    vals = '{13'(fac), 13'(wid), 13'(cf), 13'(cl), 13'(rf), 13'(rl)};
    idx = '{CFG_FACTOR, CFG_WIDTH, CFG_COL_FIRST, CFG_COL_LAST, CFG_ROW_FIRST, CFG_ROW_LAST};
    wait_idle();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_FACTOR:    r_factor = vals[i][4:0];
        CFG_WIDTH:     r_width = vals[i];
        CFG_COL_FIRST: r_col_first = vals[i][11:0];
        CFG_COL_LAST:  r_col_last = vals[i][11:0];
        CFG_ROW_FIRST: r_row_first = vals[i][11:0];
        default:       r_row_last = vals[i][11:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'(signed'($urandom_range(511)) - 256);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    out_ready <= $urandom_range(99) >= rx_idle;
  end

  always @(posedge clk) begin
    blk_res_t e, a;
    a = '{block_mean, block_valid, block_col, block_row, row_done};
    if (out_valid && out_ready) begin
      if (mean_q.size() == 0) begin
        $display("%0t: unexpected block result %h", $time, a);
        errors++;
      end else begin
        e = mean_q.pop_front();
        if (a.mean !== e.mean) begin
          $display("%0t: block_mean exp %h got %h", $time, e.mean, a.mean);
          errors++;
        end
        if (a.vld !== e.vld) begin
          $display("%0t: block_valid exp %b got %b", $time, e.vld, a.vld);
          errors++;
        end
        if (a.col !== e.col) begin
          $display("%0t: block_col exp %0d got %0d", $time, e.col, a.col);
          errors++;
        end
        if (a.row !== e.row) begin
          $display("%0t: block_row exp %0d got %0d", $time, e.row, a.row);
          errors++;
        end
        if (a.done !== e.done) begin
          $display("%0t: row_done exp %b got %b", $time, e.done, a.done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  pix_row_t dir_tbl [] = '{
    '{1'b0, 1'b1, 32'sh7fffffff, 1'b1, 1'b1, '{32'sh7fffffff, 1'b1, 12'd0, 12'd0, 1'b0}},
    '{1'b0, 1'b0, 32'sh80000000, 1'b1, 1'b1, '{32'sh80000000, 1'b1, 12'd1, 12'd0, 1'b0}},
    '{1'b0, 1'b0, 32'sh00000000, 1'b1, 1'b1, '{32'sh00000000, 1'b1, 12'd2, 12'd0, 1'b0}},
    '{1'b0, 1'b0, 32'shffffffff, 1'b1, 1'b1, '{32'shffffffff, 1'b1, 12'd3, 12'd0, 1'b0}},
    '{1'b0, 1'b0, 32'sh12345678, 1'b0, 1'b1, '{32'sh00000000, 1'b0, 12'd4, 12'd0, 1'b0}},
    '{1'b0, 1'b1, 32'sh00010000, 1'b1, 1'b1, '{32'sh00010000, 1'b1, 12'd0, 12'd0, 1'b0}},
    '{1'b0, 1'b0, 32'sh80000000, 1'b0, 1'b1, '{32'sh00000000, 1'b0, 12'd1, 12'd0, 1'b0}},
    '{1'b1, 1'b1, 32'sh7fffffff, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh7fffffff, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, -32'sd3,       1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh00000000, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh7fffffff, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh7fffffff, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh00000000, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh55555555, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh7fffffff, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh7fffffff, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh80000000, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh80000000, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh00000000, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh00000000, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 32'sh80000000, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, -32'sd1,       1'b1, 1'b0, '0}
  };

  initial begin
    int unsigned sent, n, w, f, cf, cl, rf, rl, vpct, hl;
    logic fs;
    r_factor = 5'd1;
    r_width = 13'd4096;
    r_col_first = '0;
    r_col_last = 12'd4095;
    r_row_first = '0;
    r_row_last = 12'd4095;
    pos_col = 0;
    pos_row = 0;
    foreach (line_sum[i]) begin
      line_sum[i] = 0;
      line_cnt[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle = 15;
    rx_idle = 48;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].cfg_b && !dir_tbl[i-1].cfg_b) write_cfg(2, 4, 0, 3, 0, 3);
      send_pixel(dir_tbl[i].fs, dir_tbl[i].val, dir_tbl[i].vld, dir_tbl[i].chk,
                 dir_tbl[i].res);
    end

    // out-of-range and extreme register settings
    write_cfg(13'h1f, 13'h1fff, 4095, 0, 4095, 4095);
    for (int i = 0; i < 20; i++) send_pixel(i == 0, rand_value(), 1'b1, 1'b0, '0);
    write_cfg(0, 0, 0, 4095, 0, 4095);
    for (int i = 0; i < 40; i++) begin
      send_pixel(i == 0, rand_value(), 1'($urandom_range(1)), 1'b0, '0);
    end
    write_cfg(16, 16, 0, 15, 0, 15);
    for (int i = 0; i < 256; i++) begin
      send_pixel(i == 0, $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000,
                 1'b1, 1'b0, '0);
    end

    sent = 0;
    while (sent < N_ITEMS) begin
      hl = sent * 3 / N_ITEMS;
      tx_idle = (hl == 0) ? 15 : (hl == 1) ? 48 : 0;
      rx_idle = (hl == 0) ? 48 : (hl == 1) ? 15 : 0;
      w = $urandom_range(1, 40);
      f = ($urandom_range(9) == 0) ? $urandom_range(1, MAX_F) : $urandom_range(1, 5);
      cf = $urandom_range(0, w / 3);
      cl = ($urandom_range(5) == 0) ? $urandom_range(0, 4095) : $urandom_range(cf, w);
      rf = $urandom_range(0, 3);
      rl = ($urandom_range(7) == 0) ? $urandom_range(0, 4) : rf + $urandom_range(2, 40);
      case ($urandom_range(3))
        0: vpct = 0;
        1: vpct = 50;
        default: vpct = 95;
      endcase
      n = $urandom_range(60, 200);
      write_cfg(f, w, cf, cl, rf, rl);
      for (int i = 0; i < n; i++) begin
        fs = (i == 0) || ($urandom_range(99) < 2);
        send_pixel(fs, rand_value(), $urandom_range(99) < vpct, 1'b0, '0);
      end
      sent += n;
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
